[rtl/core/gdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date counter package
// Beat types, request codes and the calendar helper functions shared by the
// date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

    // Field widths of the beats.
    localparam int DAY_FW   = 5;
    localparam int MON_W    = 4;
    localparam int YEAR_W   = 16;
    localparam int CNT_W    = 12;
    localparam int DOY_W    = 9;

    // Calendar constants.
    localparam logic [MON_W-1:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [MON_W-1:0]  MONTH_JAN       = 4'd1;
    localparam logic [MON_W-1:0]  MONTH_FEB       = 4'd2;
    localparam logic [DAY_FW-1:0] DAY_FIRST       = 5'd1;
    localparam logic [YEAR_W-1:0] YEAR_RESET      = 16'd2000;

    // Multiplicative inverse of 25 modulo 2^16, and the largest multiple
    // quotient: y is a multiple of 25 exactly when y * inverse <= 65535 / 25.
    localparam logic [YEAR_W-1:0] INV_25   = 16'd23593;
    localparam logic [YEAR_W-1:0] LIMIT_25 = 16'd2621;

    // Request codes.
    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_TICK = 2'd1,
        K_ADD  = 2'd2,
        K_CMP  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DAY_FW-1:0]  in_day;
        logic [MON_W-1:0]   in_month;
        logic [YEAR_W-1:0]  in_year;
        logic [CNT_W-1:0]   day_count;
    } t_in_beat;

    typedef struct packed {
        logic [DAY_FW-1:0]  out_day;
        logic [MON_W-1:0]   out_month;
        logic [YEAR_W-1:0]  out_year;
        logic [DOY_W-1:0]   day_of_year;
        logic               is_less;
        logic               is_equal;
        logic               is_greater;
    } t_out_beat;

    // Leap year: divisible by 4 and not by 100, or divisible by 400.
    // Divisibility by 100 is divisibility by 4 and 25; by 400 is by 16 and 25.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV_25;
        div25 = (prod <= LIMIT_25);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // Length of a month; every month code outside February and the four
    // thirty-day months counts 31 days.
    function automatic logic [DAY_FW-1:0] month_len(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_FW-1:0] len;
        case (m) inside
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in months 1 to m-1 of a common year; months 13 and 14 count 31.
    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd396;
            4'd15:   d = 9'd427;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/core/gregorian_date_counter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date counter
// Holds a day, month and year and serves load, one-day tick, add-days and
// compare requests, one result beat per request beat.
// ----------------------------------------------------------------------------
// A request beat is taken only while the unit is idle. Load, tick and compare
// pass from acceptance to the result register through accept, leap-year
// evaluation, one month step and the day-of-year sum. An add repeats the month
// step for every month boundary crossed and the leap-year evaluation for every
// year boundary crossed, as a single month-length compare and subtract is
// applied once per cycle. The result register lets the next request be
// accepted while a result beat still waits; a new result is held back only
// while the previous one has not been taken. The year wraps from 65535 to 0
// and loaded dates are stored unchecked.
module gregorian_date_counter_unit #(
    parameter int ADD_DAYS_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gdc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gdc_pkg::t_out_beat o_out_data
);
    import gdc_pkg::*;

    // Bits of day_count that take part, and the width of the working day sum.
    localparam int N_W   = (ADD_DAYS_BITS < CNT_W) ? ADD_DAYS_BITS : CNT_W;
    localparam int DAY_W = ((N_W > DAY_FW) ? N_W : DAY_FW) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEAP = 4'b0010,
        S_STEP = 4'b0100,
        S_ORD  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [MON_W-1:0]   r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic               r_leap, n_leap;
    logic               r_lt, n_lt;
    logic               r_eq, n_eq;
    logic               r_gt, n_gt;
    logic [DAY_FW-1:0]  r_held_day, n_held_day;
    logic [MON_W-1:0]   r_held_month, n_held_month;
    logic [YEAR_W-1:0]  r_held_year, n_held_year;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    logic                            accept;
    logic                            out_fire;
    logic [DAY_FW-1:0]               mlen;
    logic                            day_over;
    logic                            mon_wrap;
    logic [MON_W-1:0]                next_mon;
    logic [DAY_FW+MON_W+YEAR_W-1:0]  held_date;
    logic [DAY_FW+MON_W+YEAR_W-1:0]  given_date;
    logic                            leap_adj;
    logic [DOY_W-1:0]                ord_sum;

    // Handshake.
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_fire    = (r_state == S_ORD) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared month step: length of the working month and the rollover.
    assign mlen     = month_len(r_month, r_leap);
    assign day_over = (r_day > DAY_W'(mlen));
    assign mon_wrap = (r_month >= MONTHS_PER_YEAR);
    assign next_mon = mon_wrap ? MONTH_JAN : r_month + MON_W'(1);

    // Lexicographic date comparison, year first.
    assign held_date  = {r_held_year, r_held_month, r_held_day};
    assign given_date = {i_in_data.in_year, i_in_data.in_month, i_in_data.in_day};

    // Day of year of the working date.
    assign leap_adj = r_leap && (r_month > MONTH_FEB);
    assign ord_sum  = DOY_W'(r_day[DAY_FW-1:0]) + days_before(r_month) + DOY_W'(leap_adj);

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_day        = r_day;
        n_month      = r_month;
        n_year       = r_year;
        n_leap       = r_leap;
        n_lt         = r_lt;
        n_eq         = r_eq;
        n_gt         = r_gt;
        n_held_day   = r_held_day;
        n_held_month = r_held_month;
        n_held_year  = r_held_year;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind  = i_in_data.kind;
                    n_day   = DAY_W'(r_held_day);
                    n_month = r_held_month;
                    n_year  = r_held_year;
                    n_lt    = 1'b0;
                    n_eq    = 1'b0;
                    n_gt    = 1'b0;
                    case (i_in_data.kind)
                        K_LOAD: begin
                            n_held_day   = i_in_data.in_day;
                            n_held_month = i_in_data.in_month;
                            n_held_year  = i_in_data.in_year;
                            n_day        = DAY_W'(i_in_data.in_day);
                            n_month      = i_in_data.in_month;
                            n_year       = i_in_data.in_year;
                        end
                        K_TICK: begin
                            n_day = DAY_W'(r_held_day) + DAY_W'(1);
                        end
                        K_ADD: begin
                            n_day = DAY_W'(r_held_day)
                                  + DAY_W'(i_in_data.day_count[N_W-1:0]);
                        end
                        K_CMP: begin
                            n_lt = (held_date < given_date);
                            n_eq = (held_date == given_date);
                            n_gt = (held_date > given_date);
                        end
                        default: begin
                            n_kind = K_CMP;
                        end
                    endcase
                    n_state = S_LEAP;
                end
            end

            S_LEAP: begin
                n_leap  = is_leap(r_year);
                n_state = S_STEP;
            end

            S_STEP: begin
                case (r_kind)
                    K_TICK: begin
                        // A tick past the month end starts the next month; a
                        // year rollover lands in January, so no leap refresh.
                        if (day_over) begin
                            n_day   = DAY_W'(DAY_FIRST);
                            n_month = next_mon;
                            if (mon_wrap) begin
                                n_year = r_year + YEAR_W'(1);
                            end
                        end
                        n_state = S_ORD;
                    end
                    K_ADD: begin
                        // Peel off one month per cycle; a new year needs its
                        // leap flag before the next step.
                        if (day_over) begin
                            n_day   = r_day - DAY_W'(mlen);
                            n_month = next_mon;
                            if (mon_wrap) begin
                                n_year  = r_year + YEAR_W'(1);
                                n_state = S_LEAP;
                            end
                        end else begin
                            n_state = S_ORD;
                        end
                    end
                    default: begin
                        n_state = S_ORD;
                    end
                endcase
            end

            S_ORD: begin
                if (out_fire) begin
                    n_out.out_day     = r_day[DAY_FW-1:0];
                    n_out.out_month   = r_month;
                    n_out.out_year    = r_year;
                    n_out.day_of_year = ord_sum;
                    n_out.is_less     = r_lt;
                    n_out.is_equal    = r_eq;
                    n_out.is_greater  = r_gt;
                    n_out_valid       = 1'b1;
                    if (r_kind == K_TICK) begin
                        n_held_day   = r_day[DAY_FW-1:0];
                        n_held_month = r_month;
                        n_held_year  = r_year;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and held date.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_held_day   <= DAY_FIRST;
            r_held_month <= MONTH_JAN;
            r_held_year  <= YEAR_RESET;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_held_day   <= n_held_day;
            r_held_month <= n_held_month;
            r_held_year  <= n_held_year;
        end
    end

    // Working registers and the result beat.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_leap  <= n_leap;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
        r_gt    <= n_gt;
        r_out   <= n_out;
    end

endmodule
